// ===== src/tpce_pkg.sv =====
// shared types, constants and codebook builder for the ternary pulse expander
package tpce_pkg;

   localparam int SYM_W          = 7;
   localparam int CNT_W          = 4;
   localparam int NEG_W          = 2;
   localparam int PULSE_W        = 2;
   localparam int BYTE_W         = 8;
   localparam int BOOK_DEPTH     = 1 << SYM_W;
   localparam int MIN_WORD_LEN   = 3;
   localparam int MAX_NEG_RUN    = 3;
   localparam int MAX_WORD_LEN_D = 7;
   localparam logic [SYM_W-1:0] ALPHABET_RESET = 7'd89;

   localparam logic signed [PULSE_W-1:0] PULSE_POS  = 2'sb01;
   localparam logic signed [PULSE_W-1:0] PULSE_ZERO = 2'sb00;
   localparam logic signed [PULSE_W-1:0] PULSE_NEG  = 2'sb11;

   typedef struct packed {
      logic [CNT_W-1:0] p;
      logic [CNT_W-1:0] z;
      logic [NEG_W-1:0] n;
      logic             ok;
   } word_type;

   typedef word_type [BOOK_DEPTH-1:0] book_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic last;
   } stat_type;

   // words ranked by length, then more p, then more z; ranks past the index range are dropped
   function automatic book_type build_codebook(input int max_len);
      book_type book;
      int       seen;
      int       n;
      book = '0;
      seen = 0;
      for (int len = MIN_WORD_LEN; len <= max_len; len++) begin
         for (int p = len; p >= 0; p--) begin
            for (int z = len - p; z >= 0; z--) begin
               n = len - p - z;
               if (n <= MAX_NEG_RUN && (p + z) != 0) begin
                  if (seen < BOOK_DEPTH) begin
                     book[seen].p  = CNT_W'(p);
                     book[seen].z  = CNT_W'(z);
                     book[seen].n  = NEG_W'(n);
                     book[seen].ok = 1'b1;
                  end
                  seen++;
               end
            end
         end
      end
      return book;
   endfunction

endpackage

// ===== src/tpce_ctrl.sv =====
// controller: sequences one codeword at a time over the handshakes
module tpce_ctrl
   import tpce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_take;

   assign rsp_take   = (state_ff == ST_EMIT) && rsp_tready;
   assign rsp_tvalid = (state_ff == ST_EMIT);
   // next item may enter while the final pulse is taken
   assign req_tready = (state_ff == ST_IDLE) || (rsp_take && stat.last);

   assign cmd.load    = req_tvalid && req_tready;
   assign cmd.advance = rsp_take;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take && stat.last && !cmd.load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/tpce_dpath.sv =====
// datapath: codebook lookup, alphabet register and pulse counter
module tpce_dpath
   import tpce_pkg::*;
#(
   parameter int MAX_WORD_LEN = MAX_WORD_LEN_D
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [SYM_W-1:0]          symbol,
   input  logic                      csr_valid,
   input  logic [SYM_W-1:0]          csr_data,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   output logic signed [PULSE_W-1:0] pulse,
   output logic                      bad_symbol
);

   localparam book_type CODEBOOK = build_codebook(MAX_WORD_LEN);

   logic [SYM_W-1:0] alpha_ff;
   logic [CNT_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0] pz_ff, pz_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             bad_ff, bad_in;
   word_type         entry;

   assign entry = CODEBOOK[symbol];

   always_comb begin
      p_in   = p_ff;
      pz_in  = pz_ff;
      end_in = end_ff;
      idx_in = idx_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         bad_in = (symbol >= alpha_ff) || !entry.ok;
         p_in   = entry.p;
         pz_in  = entry.p + entry.z;
         end_in = entry.p + entry.z + CNT_W'(entry.n) - CNT_W'(1);
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHABET_RESET;
      end else if (csr_valid) begin
         alpha_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      pz_ff  <= pz_in;
      end_ff <= end_in;
      idx_ff <= idx_in;
      bad_ff <= bad_in;
   end

   always_comb begin
      if (bad_ff || idx_ff >= p_ff) begin
         pulse = (bad_ff || idx_ff < pz_ff) ? PULSE_ZERO : PULSE_NEG;
      end else begin
         pulse = PULSE_POS;
      end
   end

   assign bad_symbol = bad_ff;
   assign stat.last  = bad_ff || (idx_ff == end_ff);

endmodule

// ===== src/ternary_pulse_codebook_expander_core.sv =====
// Ternary pulse codebook expander: each accepted symbol becomes its codeword
// of +1, 0 and -1 pulses, one result item per cycle while the sink is ready,
// tlast on the final pulse. A symbol at or above the alphabet size (or past
// the end of the codebook) gives one item with pulse 0, tlast and tuser set.
// A word has 3 to MAX_WORD_LEN pulses (one item for a rejected symbol),
// counted out by the single pulse counter; the next symbol is taken in the
// cycle the final pulse leaves. The user must write the alphabet size
// register only while the block is idle; the block does not enforce it.
module ternary_pulse_codebook_expander_core
   import tpce_pkg::*;
#(
   parameter int MAX_WORD_LEN = MAX_WORD_LEN_D
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [6:0] symbol
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [1:0] pulse
   output logic              rsp_tlast,   // last
   output logic              rsp_tuser,   // bad_symbol
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SYM_W-1:0]  csr_data     // alphabet_size
);

   cmd_type                   cmd;
   stat_type                  stat;
   logic signed [PULSE_W-1:0] pulse;
   logic                      bad_symbol;

   assign csr_ready = 1'b1;

   tpce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tpce_dpath #(
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .symbol     (req_tdata[SYM_W-1:0]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .pulse      (pulse),
      .bad_symbol (bad_symbol)
   );

   assign rsp_tdata = {{(BYTE_W-PULSE_W){1'b0}}, pulse};
   assign rsp_tlast = stat.last;
   assign rsp_tuser = bad_symbol;

endmodule

// ===== tb/ternary_pulse_codebook_expander_core_tb.sv =====
// testbench for the ternary pulse codebook expander: directed and random symbols checked per pulse
`timescale 1ns / 1ps

module ternary_pulse_codebook_expander_core_tb
   import tpce_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int END_DRAIN   = 20;
   localparam int NUM_WORDS   = 89;

   typedef struct {
      logic signed [PULSE_W-1:0] pulse;
      logic                      last;
      logic                      bad;
   } pulse_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata = '0;   // [6:0] symbol
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;       // [1:0] pulse
   logic              rsp_tlast;       // last
   logic              rsp_tuser;       // bad_symbol
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SYM_W-1:0]  csr_data = '0;   // alphabet_size

   pulse_item_type    pending_pulses[$];
   pulse_item_type    rsp_want;
   logic [SYM_W-1:0]  alphabet_size;
   bit                stall_en = 1'b0;
   bit                gap_en = 1'b0;
   int                stall_left = 0;
   int                errors = 0;
   int                cycles = 0;
   int                symbols_sent = 0;
   int                pulses_seen = 0;
   int                rejects_seen = 0;
   int                size_writes = 0;

   ternary_pulse_codebook_expander_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected pulses of one symbol under the current alphabet size
   function automatic void expand_symbol(input logic [SYM_W-1:0] sym);
      int             seen;
      int             n;
      int             wp;
      int             wz;
      int             wn;
      bit             found;
      pulse_item_type it;
      seen  = 0;
      found = 1'b0;
      wp    = 0;
      wz    = 0;
      wn    = 0;
      for (int len = MIN_WORD_LEN; len <= 7; len++) begin
         for (int p = len; p >= 0; p--) begin
            for (int z = len - p; z >= 0; z--) begin
               n = len - p - z;
               if (n <= MAX_NEG_RUN && (p + z) != 0) begin
                  if (!found && seen == int'(sym)) begin
                     found = 1'b1;
                     wp    = p;
                     wz    = z;
                     wn    = n;
                  end
                  seen++;
               end
            end
         end
      end
      if (sym >= alphabet_size || !found) begin
         it.pulse = PULSE_ZERO;
         it.last  = 1'b1;
         it.bad   = 1'b1;
         pending_pulses.insert(pending_pulses.size(), it);
      end else begin
         for (int i = 0; i < wp + wz + wn; i++) begin
            it.pulse = (i < wp) ? PULSE_POS : (i < wp + wz) ? PULSE_ZERO : PULSE_NEG;
            it.last  = (i == wp + wz + wn - 1);
            it.bad   = 1'b0;
            pending_pulses.insert(pending_pulses.size(), it);
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // one symbol; tvalid stays high on return so back-to-back items never drop it
   task automatic send_symbol(input logic [SYM_W-1:0] sym);
      int gap;
      int r;
      gap = 0;
      if (gap_en) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            gap = $urandom_range(10, 40);
         else if (r < 35)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expand_symbol(sym);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, sym};
      symbols_sent++;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pulses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_alphabet_size(input logic [SYM_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid     <= 1'b0;
      alphabet_size  = value;
      size_writes++;
      @(posedge clock);
   endtask

   task automatic test_default_codebook();
      // every length-3 word, the first length-4 and length-5 words, the final word and past-the-end symbols
      for (int s = 0; s < 9; s++)
         send_symbol(SYM_W'(s));
      send_symbol(7'd9);
      send_symbol(7'd23);
      send_symbol(7'd24);
      send_symbol(7'd60);
      send_symbol(7'd87);
      send_symbol(7'd88);
      send_symbol(7'd89);
      send_symbol(7'd127);
      send_symbol(7'd85);
      send_symbol(7'd42);
      send_symbol(7'd0);
   endtask

   task automatic test_alphabet_extremes();
      write_alphabet_size(7'd1);
      send_symbol(7'd0);
      send_symbol(7'd1);
      send_symbol(7'd127);
      // zero size rejects everything
      write_alphabet_size(7'd0);
      send_symbol(7'd0);
      send_symbol(7'd5);
      // size past the codebook end still rejects missing words
      write_alphabet_size(7'd127);
      send_symbol(7'd88);
      send_symbol(7'd89);
      send_symbol(7'd100);
      send_symbol(7'd126);
      send_symbol(7'd127);
      write_alphabet_size(ALPHABET_RESET);
   endtask

   task automatic random_symbols(input int count);
      logic [SYM_W-1:0] sym;
      int               lim;
      for (int i = 0; i < count; i++) begin
         lim = (alphabet_size == 0) ? 0 : int'(alphabet_size) - 1;
         if (lim > NUM_WORDS - 1)
            lim = NUM_WORDS - 1;
         if ($urandom_range(0, 99) < 80 && alphabet_size != 0)
            sym = SYM_W'($urandom_range(0, lim));
         else
            sym = SYM_W'($urandom_range(0, 127));
         send_symbol(sym);
      end
   endtask

   task automatic test_back_to_back();
      stall_en = 1'b0;
      gap_en   = 1'b0;
      random_symbols(80);
   endtask

   task automatic test_random_stalls();
      stall_en = 1'b1;
      gap_en   = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_alphabet_size(ALPHABET_RESET);
            1: write_alphabet_size(SYM_W'($urandom_range(2, 88)));
            2: write_alphabet_size(7'd127);
            3: write_alphabet_size(SYM_W'($urandom_range(90, 126)));
            4: write_alphabet_size(SYM_W'($urandom_range(1, 20)));
            default: write_alphabet_size(ALPHABET_RESET);
         endcase
         random_symbols(35);
      end
      // a closing stretch without any idling after the stalled traffic
      stall_en = 1'b0;
      gap_en   = 1'b0;
      random_symbols(20);
   endtask

   // sink stalls: mostly short, a few long
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pulses_seen++;
         if (rsp_tuser)
            rejects_seen++;
         if (pending_pulses.size() == 0) begin
            report_mismatch($sformatf("unexpected item pulse=%0d last=%0b bad=%0b",
                                      $signed(rsp_tdata[1:0]), rsp_tlast, rsp_tuser));
         end else begin
            rsp_want = pending_pulses.pop_front();
            if (rsp_tdata[1:0] !== rsp_want.pulse)
               report_mismatch($sformatf("pulse expected %0d got %0d",
                                         rsp_want.pulse, $signed(rsp_tdata[1:0])));
            if (rsp_tlast !== rsp_want.last)
               report_mismatch($sformatf("last expected %0b got %0b",
                                         rsp_want.last, rsp_tlast));
            if (rsp_tuser !== rsp_want.bad)
               report_mismatch($sformatf("bad_symbol expected %0b got %0b",
                                         rsp_want.bad, rsp_tuser));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding",
                  cycles, pending_pulses.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      alphabet_size = ALPHABET_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_codebook();
      test_alphabet_extremes();
      test_back_to_back();
      test_random_stalls();
      drain_results();
      repeat (END_DRAIN) @(posedge clock);
      if (pending_pulses.size() != 0)
         report_mismatch($sformatf("%0d expected items never arrived", pending_pulses.size()));
      $display("sent %0d symbols over %0d alphabet size writes", symbols_sent, size_writes);
      $display("checked %0d pulses, %0d of them rejections, %0d mismatches",
               pulses_seen, rejects_seen, errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tpce_pkg.sv
src/tpce_ctrl.sv
src/tpce_dpath.sv
src/ternary_pulse_codebook_expander_core.sv
tb/ternary_pulse_codebook_expander_core_tb.sv
